// File: hw/rtl/fixed_point_to_decimal_ascii_macros.svh
// Assertion macros used by the checker of this block.
`ifndef FIXED_POINT_TO_DECIMAL_ASCII_MACROS_SVH
`define FIXED_POINT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define FP2DEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fp2dec check failed");

// Next-cycle implication.
`define FP2DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fp2dec check failed");

`endif

// File: hw/rtl/fp2dec_pkg.sv
`timescale 1ns / 1ps
package fp2dec_pkg;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int INT_DIGITS_DEF      = 5;
    localparam int MAX_FRAC_DIGITS_DEF = 4;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 3;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [APB_AW-1:0] ADDR_FRAC_DIGITS = 3'd0;
    localparam logic [CFG_W-1:0]  FRAC_DIGITS_RST  = 3'd3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2e;

    typedef struct packed {
        logic load;
        logic conv;
        logic prep;
        logic emit_int;
        logic emit_dot;
        logic emit_frac;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic int_last;
        logic frac_last;
        logic no_frac;
        logic out_free;
    } t_stat;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction
endpackage

// File: hw/rtl/fixed_point_to_decimal_ascii.sv
// The request is taken in idle; the binary-to-BCD shift then takes one integer bit per
// cycle, a prep step selects the top digit and the first character is registered. A number
// gives N = 1..INT_DIGITS+1+MAX_FRAC_DIGITS characters, one leaving per cycle unless the
// output stalls; a new number is taken only after the last character of the last one is issued.
// Reset: synchronous active low; clears the controller, output valid and frac_digits to 3.
`timescale 1ns / 1ps
module fixed_point_to_decimal_ascii #(
    parameter int FRAC_BITS       = fp2dec_pkg::FRAC_BITS_DEF,
    parameter int INT_DIGITS      = fp2dec_pkg::INT_DIGITS_DEF,
    parameter int MAX_FRAC_DIGITS = fp2dec_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fp2dec_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fp2dec_pkg::CHAR_W-1:0]  m_axis_tdata,  // [7:0] char_code
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fp2dec_pkg::APB_AW-1:0]  paddr,
    input  logic [fp2dec_pkg::APB_DW-1:0]  pwdata,
    output logic [fp2dec_pkg::APB_DW-1:0]  prdata,
    output logic                           pready
);
    logic [fp2dec_pkg::CFG_W-1:0] r_frac_digits;
    fp2dec_pkg::t_cmd             w_cmd;
    fp2dec_pkg::t_stat            w_stat;

    assign pready = 1'b1;
    assign prdata = (paddr == fp2dec_pkg::ADDR_FRAC_DIGITS)
                    ? fp2dec_pkg::APB_DW'(r_frac_digits) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_digits <= fp2dec_pkg::FRAC_DIGITS_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr == fp2dec_pkg::ADDR_FRAC_DIGITS) begin
            r_frac_digits <= pwdata[fp2dec_pkg::CFG_W-1:0];
        end
    end

    fp2dec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fp2dec_dpath #(
        .FRAC_BITS       (FRAC_BITS),
        .INT_DIGITS      (INT_DIGITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (s_axis_tdata),
        .i_frac_digits (r_frac_digits),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_char        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );
endmodule

// File: hw/rtl/fp2dec_ctrl.sv
`timescale 1ns / 1ps
module fp2dec_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fp2dec_pkg::t_stat i_stat,
    output fp2dec_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_INT  = 3'd3;
    localparam logic [2:0] S_DOT  = 3'd4;
    localparam logic [2:0] S_FRAC = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_stat.conv_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_INT;
            end
            S_INT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_int = 1'b1;
                    if (i_stat.int_last) begin
                        n_state = i_stat.no_frac ? S_IDLE : S_DOT;
                    end
                end
            end
            S_DOT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_dot = 1'b1;
                    n_state        = S_FRAC;
                end
            end
            S_FRAC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_frac = 1'b1;
                    if (i_stat.frac_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: hw/rtl/fp2dec_dpath.sv
`timescale 1ns / 1ps
module fp2dec_dpath #(
    parameter int FRAC_BITS       = fp2dec_pkg::FRAC_BITS_DEF,
    parameter int INT_DIGITS      = fp2dec_pkg::INT_DIGITS_DEF,
    parameter int MAX_FRAC_DIGITS = fp2dec_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [fp2dec_pkg::VALUE_W-1:0] i_value,
    input  logic [fp2dec_pkg::CFG_W-1:0]   i_frac_digits,
    input  fp2dec_pkg::t_cmd               i_cmd,
    output fp2dec_pkg::t_stat              o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [fp2dec_pkg::CHAR_W-1:0]  o_char,
    output logic                          o_last
);
    localparam int IW  = fp2dec_pkg::VALUE_W - FRAC_BITS;
    localparam int BW  = 4 * INT_DIGITS;
    localparam int CW  = $clog2(IW);
    localparam int IXW = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
    localparam int FCW = $clog2(MAX_FRAC_DIGITS + 1);
    localparam logic [63:0] LIMIT = fp2dec_pkg::pow10(INT_DIGITS) - 64'd1;

    logic [IW-1:0]          r_bin;
    logic [BW-1:0]          r_bcd;
    logic [CW-1:0]          r_bit_cnt;
    logic [IXW-1:0]         r_idx;
    logic [FRAC_BITS-1:0]   r_frac;
    logic [FCW-1:0]         r_fcnt;
    logic                   r_out_valid;
    logic [fp2dec_pkg::CHAR_W-1:0] r_char;
    logic                   r_last;

    logic [63:0]            w_ipart;
    logic [63:0]            w_sat;
    logic [FCW-1:0]         w_k;
    logic [BW-1:0]          w_adj;
    logic [IXW-1:0]         w_top;
    logic [3:0]             w_digit;
    logic [FRAC_BITS+3:0]   w_f10;
    logic                   w_emit;

    assign w_ipart = 64'(i_value[fp2dec_pkg::VALUE_W-1:FRAC_BITS]);
    assign w_sat   = (w_ipart > LIMIT) ? LIMIT : w_ipart;
    assign w_k     = (32'(i_frac_digits) > MAX_FRAC_DIGITS) ? FCW'(MAX_FRAC_DIGITS)
                                                           : FCW'(i_frac_digits);

    always_comb begin
        w_adj = r_bcd;
        for (int d = 0; d < INT_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        w_top = '0;
        for (int d = 0; d < INT_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                w_top = IXW'(d);
            end
        end
    end

    assign w_digit = r_bcd[{r_idx, 2'b00} +: 4];
    assign w_f10   = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign w_emit  = i_cmd.emit_int | i_cmd.emit_dot | i_cmd.emit_frac;

    assign o_stat.conv_last = (r_bit_cnt == CW'(IW - 1));
    assign o_stat.int_last  = (r_idx == '0);
    assign o_stat.frac_last = (r_fcnt == FCW'(1));
    assign o_stat.no_frac   = (r_fcnt == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= w_sat[IW-1:0];
            r_bcd     <= '0;
            r_bit_cnt <= '0;
            r_frac    <= i_value[FRAC_BITS-1:0];
            r_fcnt    <= w_k;
        end else if (i_cmd.conv) begin
            r_bin     <= {r_bin[IW-2:0], 1'b0};
            r_bcd     <= {w_adj[BW-2:0], r_bin[IW-1]};
            r_bit_cnt <= r_bit_cnt + CW'(1);
        end else if (i_cmd.prep) begin
            r_idx <= w_top;
        end else if (i_cmd.emit_int) begin
            r_idx <= r_idx - IXW'(1);
        end else if (i_cmd.emit_frac) begin
            r_frac <= w_f10[FRAC_BITS-1:0];
            r_fcnt <= r_fcnt - FCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_int) begin
            r_char <= fp2dec_pkg::ASCII_ZERO + {4'b0000, w_digit};
            r_last <= o_stat.int_last && o_stat.no_frac;
        end else if (i_cmd.emit_dot) begin
            r_char <= fp2dec_pkg::ASCII_DOT;
            r_last <= 1'b0;
        end else if (i_cmd.emit_frac) begin
            r_char <= fp2dec_pkg::ASCII_ZERO + {4'b0000, w_f10[FRAC_BITS+3:FRAC_BITS]};
            r_last <= o_stat.frac_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char      = r_char;
    assign o_last      = r_last;
endmodule

// File: hw/rtl/fp2dec_checker.sv
`timescale 1ns / 1ps
`include "fixed_point_to_decimal_ascii_macros.svh"
module fp2dec_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [fp2dec_pkg::CHAR_W-1:0] i_m_tdata,
    input logic                          i_m_tlast
);
    logic w_stall;

    assign w_stall = i_m_tvalid && !i_m_tready;

    `FP2DEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_m_tvalid)
    `FP2DEC_ASSERT_NEXT(a_data_stable, i_clk, i_rst_n, w_stall, $stable(i_m_tdata))
    `FP2DEC_ASSERT_NEXT(a_last_stable, i_clk, i_rst_n, w_stall, $stable(i_m_tlast))
    `FP2DEC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)
    `FP2DEC_ASSERT_NOW(a_busy_mid_text, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, !i_s_tready)
endmodule

bind fixed_point_to_decimal_ascii fp2dec_checker u_fp2dec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);
